>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the zoom shuttle controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`endif

>>> rtl/zpsc_pkg.sv
// ----------------------------------------------------------------------------
// zpsc_pkg
// Types and constants shared by the zoom position shuttle controller.
// ----------------------------------------------------------------------------
`default_nettype none

package zpsc_pkg;

    localparam int POSITION_BITS = 16;
    localparam int MIN_POSITION  = 200;
    localparam int DEADBAND      = 50;
    localparam int FOV_BITS      = 11;
    localparam int DIV_CNT_W     = $clog2(FOV_BITS);

    localparam logic [15:0] MAX_POSITION_RESET = 16'd8000;
    localparam logic [10:0] WIDE_ANGLE_RESET   = 11'd371;

    localparam logic signed [15:0] SPEED_POS_THRESHOLD = 16'sd6554;
    localparam logic signed [15:0] SPEED_NEG_THRESHOLD = -16'sd6554;

    localparam logic [63:0] LIM_CAP_WIDE = (64'd1 << POSITION_BITS) - 64'd1;
    localparam logic [15:0] LIM_CAP      = (POSITION_BITS >= 16) ? 16'hFFFF
                                                                 : LIM_CAP_WIDE[15:0];

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_RELATIVE   = 2'd2,
        OP_STOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DRIVE_STOP = 2'd0,
        DRIVE_IN   = 2'd1,
        DRIVE_OUT  = 2'd2
    } drive_t;

    typedef enum logic [0:0] {
        REG_MAX_POSITION = 1'b0,
        REG_WIDE_ANGLE   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_DECIDE,
        S_TGT_CLAMP,
        S_FOV_MUL,
        S_DIV_INIT,
        S_DIV_STEP,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic tick_decide;
        logic tgt_clamp;
        logic fov_mul;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t op;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/zoom_position_shuttle_controller.sv
// Zoom position shuttle controller.
// Input channel (in_valid / in_stall) carries one beat per command: op selects
// a tick (elapsed_ms), a set-target call (zoom_factor), a relative speed
// (speed) or a stop-shuttle call. Every input beat yields exactly one output
// beat (out_valid / out_stall) with position, target, drive, shuttling,
// zooming and field_of_view.
// Sequence: capture, execute, then for ticks the shuttle decision and for
// set-target calls the target clamp, then the field-of-view multiply, the
// divider set-up, the eleven-step restoring divider and the output load. The
// block returns to idle as out_valid rises and takes no new beat before then.
// A finished result sits in the output register; the next input beat is taken
// while it waits. If the receiver still stalls when the following result is
// ready, the block holds in its last step until the waiting beat is taken.
// Reset is asynchronous and active low: position returns to 8000, target and
// all flags clear, registers return to 8000 and 371, and no beat is pending.
// The register port is APB style: max_position at offset 0, wide_angle at 4.
// ----------------------------------------------------------------------------
// zoom_position_shuttle_controller
// Top level: register bank, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module zoom_position_shuttle_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [1:0]  op,
    input  wire logic        [15:0] elapsed_ms,
    input  wire logic        [15:0] zoom_factor,
    input  wire logic signed [15:0] speed,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [15:0] position,
    output logic             [15:0] target,
    output logic             [1:0]  drive,
    output logic                    shuttling,
    output logic                    zooming,
    output logic             [10:0] field_of_view
);

    logic [15:0]        max_position;
    logic [10:0]        wide_angle;
    zpsc_pkg::cmd_t     cmd;
    zpsc_pkg::status_t  status;

    zpsc_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .max_position (max_position),
        .wide_angle   (wide_angle)
    );

    zpsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    zpsc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .max_position  (max_position),
        .wide_angle    (wide_angle),
        .op            (op),
        .elapsed_ms    (elapsed_ms),
        .zoom_factor   (zoom_factor),
        .speed         (speed),
        .position      (position),
        .target        (target),
        .drive         (drive),
        .shuttling     (shuttling),
        .zooming       (zooming),
        .field_of_view (field_of_view)
    );

endmodule

`default_nettype wire

>>> rtl/zpsc_regs.sv
// ----------------------------------------------------------------------------
// zpsc_regs
// APB-style register bank holding the travel limit and the wide angle.
// ----------------------------------------------------------------------------
`default_nettype none

module zpsc_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [15:0] max_position,
    output logic      [10:0] wide_angle
);

    logic [15:0] max_position_reg;
    logic [10:0] wide_angle_reg;
    logic        wr_en;
    zpsc_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    // Word addressing: the byte-offset bits are ignored.
    assign idx    = zpsc_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_position_reg <= zpsc_pkg::MAX_POSITION_RESET;
            wide_angle_reg   <= zpsc_pkg::WIDE_ANGLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                zpsc_pkg::REG_MAX_POSITION: max_position_reg <= pwdata[15:0];
                zpsc_pkg::REG_WIDE_ANGLE:   wide_angle_reg   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            zpsc_pkg::REG_MAX_POSITION: prdata = {16'd0, max_position_reg};
            zpsc_pkg::REG_WIDE_ANGLE:   prdata = {21'd0, wide_angle_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign max_position = max_position_reg;
    assign wide_angle   = wide_angle_reg;

endmodule

`default_nettype wire

>>> rtl/zpsc_ctrl.sv
// ----------------------------------------------------------------------------
// zpsc_ctrl
// Sequencer: steps each item through update, field-of-view multiply,
// division and output load, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module zpsc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire zpsc_pkg::status_t  status,
    output zpsc_pkg::cmd_t          cmd
);

    localparam int CW = zpsc_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(zpsc_pkg::FOV_BITS - 1);

    zpsc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zpsc_pkg::S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        // A beat on the output clears the valid unless a new result is loaded.
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            zpsc_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = zpsc_pkg::S_EXEC;
                end
            end
            zpsc_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (status.op)
                    zpsc_pkg::OP_TICK:       state_next = zpsc_pkg::S_TICK_DECIDE;
                    zpsc_pkg::OP_SET_TARGET: state_next = zpsc_pkg::S_TGT_CLAMP;
                    default:                 state_next = zpsc_pkg::S_FOV_MUL;
                endcase
            end
            zpsc_pkg::S_TICK_DECIDE:
            begin
                cmd.tick_decide = 1'b1;
                state_next      = zpsc_pkg::S_FOV_MUL;
            end
            zpsc_pkg::S_TGT_CLAMP:
            begin
                cmd.tgt_clamp = 1'b1;
                state_next    = zpsc_pkg::S_FOV_MUL;
            end
            zpsc_pkg::S_FOV_MUL:
            begin
                cmd.fov_mul = 1'b1;
                state_next  = zpsc_pkg::S_DIV_INIT;
            end
            zpsc_pkg::S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = zpsc_pkg::S_DIV_STEP;
            end
            zpsc_pkg::S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + CW'(1);
                if (div_cnt_reg == LAST_STEP)
                begin
                    state_next = zpsc_pkg::S_OUT_WAIT;
                end
            end
            zpsc_pkg::S_OUT_WAIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = zpsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = zpsc_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_accept_starts_exec, clk, rst_n, in_valid && !in_stall, state_reg == zpsc_pkg::S_EXEC)
    `ASSERT_IMPLIES(a_load_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall)
    `ASSERT_IMPLIES(a_div_count_range, clk, rst_n, state_reg == zpsc_pkg::S_DIV_STEP, div_cnt_reg <= LAST_STEP)
    `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.out_load, out_valid_reg)

endmodule

`default_nettype wire

>>> rtl/zpsc_dp.sv
// ----------------------------------------------------------------------------
// zpsc_dp
// Datapath: position and target state, shuttle flags, the shared product
// register and a bit-per-cycle restoring divider for the field of view.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module zpsc_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire zpsc_pkg::cmd_t     cmd,
    output zpsc_pkg::status_t       status,
    input  wire logic        [15:0] max_position,
    input  wire logic        [10:0] wide_angle,
    input  wire logic        [1:0]  op,
    input  wire logic        [15:0] elapsed_ms,
    input  wire logic        [15:0] zoom_factor,
    input  wire logic signed [15:0] speed,
    output logic             [15:0] position,
    output logic             [15:0] target,
    output logic             [1:0]  drive,
    output logic                    shuttling,
    output logic                    zooming,
    output logic             [10:0] field_of_view
);

    localparam int QB = zpsc_pkg::FOV_BITS;
    localparam logic [16:0] MIN17  = 17'(zpsc_pkg::MIN_POSITION);
    localparam logic [16:0] BAND17 = 17'(zpsc_pkg::DEADBAND);
    localparam logic [QB-1:0] Q_SAT = {QB{1'b1}};

    // Item state
    logic [15:0] pos_reg, tgt_reg;
    logic        din_reg, dout_reg, shut_reg, rin_reg, rout_reg;

    // Captured item
    zpsc_pkg::op_t      op_reg;
    logic [15:0]        elapsed_reg, zf_reg;
    logic signed [15:0] speed_reg;

    // Arithmetic
    logic [31:0]   prod_reg;
    logic [15:0]   rem_reg;
    logic [QB-1:0] nlow_reg, quo_reg;
    logic          skip_reg;

    // Result beat
    logic [15:0]   position_reg, target_reg;
    logic [1:0]    drive_reg;
    logic          shuttling_reg, zooming_reg;
    logic [QB-1:0] fov_reg;

    logic [15:0] lim;
    logic [16:0] pos17, lim17, sum17, tgt_dec17, tset17, tmin17;
    logic [15:0] tgt_dec, tgt_set;
    logic [26:0] dividend;
    logic        fov_sat;
    logic [16:0] rem_ext;
    logic        rem_ge;

    assign lim   = (max_position < zpsc_pkg::LIM_CAP) ? max_position : zpsc_pkg::LIM_CAP;
    assign pos17 = {1'b0, pos_reg};
    assign lim17 = {1'b0, lim};
    assign sum17 = pos17 + {1'b0, elapsed_reg};

    // Target seen by the shuttle decision: relative out mode overrides in mode.
    assign tgt_dec   = rout_reg ? 16'd0 : (rin_reg ? lim : tgt_reg);
    assign tgt_dec17 = {1'b0, tgt_dec};

    assign tset17  = prod_reg[31:15];
    assign tmin17  = (tset17 < MIN17) ? MIN17 : tset17;
    assign tgt_set = (tmin17 > lim17) ? lim : tmin17[15:0];

    assign dividend = prod_reg[26:0];
    assign fov_sat  = (lim == 16'd0) || (dividend >= {lim, {QB{1'b0}}});
    assign rem_ext  = {rem_reg, nlow_reg[QB-1]};
    assign rem_ge   = rem_ext >= lim17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= zpsc_pkg::MAX_POSITION_RESET;
            tgt_reg  <= 16'd0;
            din_reg  <= 1'b0;
            dout_reg <= 1'b0;
            shut_reg <= 1'b0;
            rin_reg  <= 1'b0;
            rout_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                zpsc_pkg::OP_TICK:
                begin
                    if (din_reg)
                    begin
                        if (pos17 < ({1'b0, elapsed_reg} + MIN17))
                        begin
                            pos_reg  <= MIN17[15:0];
                            shut_reg <= 1'b0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - elapsed_reg;
                        end
                    end
                    else if (dout_reg)
                    begin
                        if (sum17 > lim17)
                        begin
                            pos_reg  <= lim;
                            shut_reg <= 1'b0;
                        end
                        else
                        begin
                            pos_reg <= sum17[15:0];
                        end
                    end
                end
                zpsc_pkg::OP_RELATIVE:
                begin
                    if (speed_reg >= zpsc_pkg::SPEED_POS_THRESHOLD)
                    begin
                        rin_reg  <= 1'b1;
                        shut_reg <= 1'b1;
                    end
                    else if (speed_reg <= zpsc_pkg::SPEED_NEG_THRESHOLD)
                    begin
                        rout_reg <= 1'b1;
                        shut_reg <= 1'b1;
                    end
                    else
                    begin
                        rin_reg  <= 1'b0;
                        rout_reg <= 1'b0;
                        shut_reg <= 1'b0;
                    end
                end
                zpsc_pkg::OP_STOP:
                begin
                    shut_reg <= 1'b0;
                end
                default: ;
            endcase
        end
        else if (cmd.tick_decide)
        begin
            tgt_reg <= tgt_dec;
            if (shut_reg && (tgt_dec != pos_reg) && ((tgt_dec17 + BAND17) < pos17))
            begin
                din_reg  <= 1'b1;
                dout_reg <= 1'b0;
            end
            else if (shut_reg && (tgt_dec != pos_reg) && (tgt_dec17 > (pos17 + BAND17)))
            begin
                din_reg  <= 1'b0;
                dout_reg <= 1'b1;
            end
            else
            begin
                din_reg  <= 1'b0;
                dout_reg <= 1'b0;
                shut_reg <= 1'b0;
            end
        end
        else if (cmd.tgt_clamp)
        begin
            tgt_reg <= tgt_set;
            if (tgt_set != pos_reg)
            begin
                shut_reg <= 1'b1;
            end
        end
    end

    // Capture, arithmetic and result registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= zpsc_pkg::op_t'(op);
            elapsed_reg <= elapsed_ms;
            zf_reg      <= zoom_factor;
            speed_reg   <= speed;
        end

        if (cmd.exec)
        begin
            prod_reg <= 32'(zf_reg) * 32'(lim);
        end
        else if (cmd.fov_mul)
        begin
            prod_reg <= 32'(wide_angle) * 32'(pos_reg);
        end

        if (cmd.div_init)
        begin
            rem_reg  <= dividend[26:QB];
            nlow_reg <= dividend[QB-1:0];
            skip_reg <= fov_sat;
            quo_reg  <= (lim == 16'd0) ? '0 : Q_SAT;
        end
        else if (cmd.div_step && !skip_reg)
        begin
            nlow_reg <= {nlow_reg[QB-2:0], 1'b0};
            if (rem_ge)
            begin
                rem_reg <= 16'(rem_ext - lim17);
                quo_reg <= {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_ext[15:0];
                quo_reg <= {quo_reg[QB-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            position_reg  <= pos_reg;
            target_reg    <= tgt_reg;
            drive_reg     <= din_reg  ? zpsc_pkg::DRIVE_IN :
                             dout_reg ? zpsc_pkg::DRIVE_OUT : zpsc_pkg::DRIVE_STOP;
            shuttling_reg <= shut_reg;
            zooming_reg   <= din_reg || dout_reg || shut_reg;
            fov_reg       <= quo_reg;
        end
    end

    assign status.op     = op_reg;
    assign position      = position_reg;
    assign target        = target_reg;
    assign drive         = drive_reg;
    assign shuttling     = shuttling_reg;
    assign zooming       = zooming_reg;
    assign field_of_view = fov_reg;

    // The drive flags are set by the shuttle decision alone and never together.
    `ASSERT_IMPLIES(a_drive_exclusive, clk, rst_n, 1'b1, !(din_reg && dout_reg))
    // The partial remainder stays below the divisor throughout the division.
    `ASSERT_IMPLIES(a_rem_below_lim, clk, rst_n, cmd.div_step && !skip_reg, rem_reg < lim)

endmodule

`default_nettype wire

>>> tb/sv/zpsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpsc_checker
// Watches the register port and both beat channels of the zoom position
// shuttle controller. It predicts the result of every accepted command from
// its own copy of the lens state and compares each returned beat, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module zpsc_checker
    import zpsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic        [1:0]  op,
    input  logic        [15:0] elapsed_ms,
    input  logic        [15:0] zoom_factor,
    input  logic signed [15:0] speed,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic        [15:0] position,
    input  logic        [15:0] target,
    input  logic        [1:0]  drive,
    input  logic               shuttling,
    input  logic               zooming,
    input  logic        [10:0] field_of_view,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] target;
        drive_t      drive;
        logic        shuttling;
        logic        zooming;
        logic [10:0] fov;
    } lens_report_t;

    logic [15:0] travel_reg;
    logic [10:0] wide_reg;
    logic [15:0] pos_est;
    logic [15:0] tgt_pos;
    logic        drv_in;
    logic        drv_out;
    logic        shut_on;
    logic        rel_in;
    logic        rel_out;

    lens_report_t lens_reports[$];
    int           err_cnt;
    int           chk_cnt;
    int           pending_q;

    assign errors  = err_cnt;
    assign checked = chk_cnt;
    assign pending = pending_q;

    function automatic logic [15:0] travel_limit();
        return (travel_reg < LIM_CAP) ? travel_reg : LIM_CAP;
    endfunction

    task automatic advance_position(input logic [15:0] elapsed);
        logic [15:0] lim;
        int          down;
        logic [16:0] up;
        int          t;
        int          p;
        lim = travel_limit();
        if (drv_in)
        begin
            down = int'(pos_est) - int'(elapsed);
            if (down < MIN_POSITION)
            begin
                down    = MIN_POSITION;
                shut_on = 1'b0;
            end
            pos_est = down[15:0];
        end
        if (drv_out)
        begin
            up = {1'b0, pos_est} + {1'b0, elapsed};
            if (up > {1'b0, lim})
            begin
                up      = {1'b0, lim};
                shut_on = 1'b0;
            end
            pos_est = up[15:0];
        end
        // Both relative modes may be set; the outward one is applied last.
        if (rel_in)
            tgt_pos = lim;
        if (rel_out)
            tgt_pos = '0;
        t = int'(tgt_pos);
        p = int'(pos_est);
        if (shut_on && t != p && t + DEADBAND < p)
        begin
            drv_in  = 1'b1;
            drv_out = 1'b0;
        end
        else if (shut_on && t != p && t > p + DEADBAND)
        begin
            drv_out = 1'b1;
            drv_in  = 1'b0;
        end
        else
        begin
            shut_on = 1'b0;
            drv_in  = 1'b0;
            drv_out = 1'b0;
        end
    endtask

    task automatic aim_target(input logic [15:0] factor);
        logic [15:0] lim;
        logic [31:0] scaled;
        lim    = travel_limit();
        scaled = (32'(factor) * 32'(lim)) >> 15;
        if (scaled < MIN_POSITION)
            scaled = MIN_POSITION;
        if (scaled > lim)
            scaled = lim;
        tgt_pos = scaled[15:0];
        if (tgt_pos != pos_est)
            shut_on = 1'b1;
    endtask

    task automatic apply_speed(input logic signed [15:0] rate);
        if (rate >= SPEED_POS_THRESHOLD)
        begin
            rel_in  = 1'b1;
            shut_on = 1'b1;
        end
        else if (rate <= SPEED_NEG_THRESHOLD)
        begin
            rel_out = 1'b1;
            shut_on = 1'b1;
        end
        else
        begin
            rel_in  = 1'b0;
            rel_out = 1'b0;
            shut_on = 1'b0;
        end
    endtask

    task automatic predict_lens(input op_t cmd, input logic [15:0] elapsed,
                                input logic [15:0] factor, input logic signed [15:0] rate,
                                output lens_report_t rpt);
        logic [15:0] lim;
        logic [63:0] angle;
        case (cmd)
            OP_TICK:       advance_position(elapsed);
            OP_SET_TARGET: aim_target(factor);
            OP_RELATIVE:   apply_speed(rate);
            OP_STOP:       shut_on = 1'b0;
            default:       ;
        endcase
        lim = travel_limit();
        if (lim == '0)
            angle = '0;
        else
        begin
            angle = (64'(wide_reg) * 64'(pos_est)) / 64'(lim);
            if (angle > 64'd2047)
                angle = 64'd2047;
        end
        rpt.position  = pos_est;
        rpt.target    = tgt_pos;
        rpt.drive     = drv_in ? DRIVE_IN : (drv_out ? DRIVE_OUT : DRIVE_STOP);
        rpt.shuttling = shut_on;
        rpt.zooming   = drv_in | drv_out | shut_on;
        rpt.fov       = angle[10:0];
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lens_report_t got;
        lens_report_t want;
        if (!rst_n)
        begin
            travel_reg = MAX_POSITION_RESET;
            wide_reg   = WIDE_ANGLE_RESET;
            pos_est    = MAX_POSITION_RESET;
            tgt_pos    = '0;
            drv_in     = 1'b0;
            drv_out    = 1'b0;
            shut_on    = 1'b0;
            rel_in     = 1'b0;
            rel_out    = 1'b0;
            err_cnt    = 0;
            chk_cnt    = 0;
            lens_reports.delete();
            pending_q <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_MAX_POSITION: travel_reg = pwdata[15:0];
                    REG_WIDE_ANGLE:   wide_reg   = pwdata[10:0];
                    default:          ;
                endcase
            end
            // A result always belongs to a command accepted at an earlier edge,
            // so the returned beat is checked before this edge's command is
            // predicted.
            if (out_valid && !out_stall)
            begin
                got.position  = position;
                got.target    = target;
                got.drive     = drive_t'(drive);
                got.shuttling = shuttling;
                got.zooming   = zooming;
                got.fov       = field_of_view;
                if (lens_reports.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result beat with no command waiting, position %0d",
                             $time, position);
                end
                else
                begin
                    want = lens_reports.pop_front();
                    compare_field("position", want.position, got.position);
                    compare_field("target", want.target, got.target);
                    compare_field("drive", int'(want.drive), int'(got.drive));
                    compare_field("shuttling", want.shuttling, got.shuttling);
                    compare_field("zooming", want.zooming, got.zooming);
                    compare_field("field_of_view", want.fov, got.fov);
                    chk_cnt++;
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_lens(op_t'(op), elapsed_ms, zoom_factor, speed, want);
                lens_reports.push_back(want);
            end
            pending_q <= lens_reports.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the zoom position shuttle controller with a directed opening and
// then random command sequences under several travel and angle settings,
// with random idling on both channels. The checker beside the block does the
// prediction; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
    import zpsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 20;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [2:0]  paddr;
    logic        [31:0] pwdata;
    logic        [31:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic        [1:0]  op;
    logic        [15:0] elapsed_ms;
    logic        [15:0] zoom_factor;
    logic signed [15:0] speed;
    logic               out_valid;
    logic               out_stall;
    logic        [15:0] position;
    logic        [15:0] target;
    logic        [1:0]  drive;
    logic               shuttling;
    logic               zooming;
    logic        [10:0] field_of_view;

    int errors;
    int pending;
    int checked;
    int items_sent;
    int settings_used;
    int cur_travel;
    int idle_cycles;
    bit calm;

    zoom_position_shuttle_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .elapsed_ms    (elapsed_ms),
        .zoom_factor   (zoom_factor),
        .speed         (speed),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .target        (target),
        .drive         (drive),
        .shuttling     (shuttling),
        .zooming       (zooming),
        .field_of_view (field_of_view)
    );

    zpsc_checker lens_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .elapsed_ms    (elapsed_ms),
        .zoom_factor   (zoom_factor),
        .speed         (speed),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .target        (target),
        .drive         (drive),
        .shuttling     (shuttling),
        .zooming       (zooming),
        .field_of_view (field_of_view),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver holds off in random bursts until the calm final stretch.
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat accepted for %0d cycles at %0t",
                         idle_cycles, $time);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Unused payload fields carry random values so that every bit toggles.
    task automatic issue(input op_t cmd, input logic [15:0] arg);
        logic [15:0] e;
        logic [15:0] z;
        logic [15:0] s;
        e = 16'($urandom);
        z = 16'($urandom);
        s = 16'($urandom);
        case (cmd)
            OP_TICK:       e = arg;
            OP_SET_TARGET: z = arg;
            OP_RELATIVE:   s = arg;
            default:       ;
        endcase
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= cmd;
        elapsed_ms  <= e;
        zoom_factor <= z;
        speed       <= s;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Registers change only once every result has come back and the block
    // has had time to fall idle. The first edge lets the pending count take
    // in the command accepted just before.
    task automatic set_travel(input logic [15:0] travel, input logic [10:0] angle);
        logic [31:0] noise;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        noise = $urandom;
        apb_write(REG_MAX_POSITION, {noise[31:16], travel});
        apb_write(REG_WIDE_ANGLE, {noise[20:0], angle});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur_travel = travel;
        settings_used++;
    endtask

    // Mostly short steps, scaled to the travel, so targets are reached and the
    // deadband is met; now and then a huge step to hit the end stops.
    function automatic logic [15:0] pick_elapsed();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 16'($urandom_range(0, cur_travel / 12 + 1));
        else if (pick < 17)
            return 16'($urandom_range(0, cur_travel / 2 + 1));
        else if (pick < 19)
            return 16'($urandom);
        else
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [15:0] pick_factor();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return 16'($urandom);
        else if (pick < 8)
            return 16'($urandom_range(0, 400));
        else if (pick < 9)
            return 16'($urandom_range(32700, 32800));
        else
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [15:0] pick_speed();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = $urandom_range(6554, 32767);
        else if (pick < 8)
            v = -int'($urandom_range(6554, 32768));
        else
            v = int'($urandom_range(0, 13106)) - 6553;
        return 16'(v);
    endfunction

    task automatic run_random(input int count);
        int done;
        int kind;
        int n;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(0, 99);
            n    = $urandom_range(2, 12);
            if (kind < 60)
            begin
                issue(OP_SET_TARGET, pick_factor());
                repeat (n) issue(OP_TICK, pick_elapsed());
                done += n + 1;
            end
            else if (kind < 75)
            begin
                issue(OP_RELATIVE, pick_speed());
                repeat (n) issue(OP_TICK, pick_elapsed());
                done += n + 1;
            end
            else if (kind < 85)
            begin
                // A shuttle broken off part way: the motor runs on to the next tick.
                issue(OP_SET_TARGET, pick_factor());
                issue(OP_TICK, pick_elapsed());
                issue(OP_STOP, 16'($urandom));
                repeat (n) issue(OP_TICK, pick_elapsed());
                done += n + 3;
            end
            else
            begin
                issue(op_t'($urandom_range(0, 3)), 16'($urandom));
                done += 1;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        op            = OP_TICK;
        elapsed_ms    = '0;
        zoom_factor   = '0;
        speed         = '0;
        items_sent    = 0;
        settings_used = 1;
        cur_travel    = MAX_POSITION_RESET;
        calm          = 1'b0;
        idle_cycles   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset settings.
        issue(OP_TICK, 16'h0000);
        issue(OP_TICK, 16'hFFFF);
        issue(OP_STOP, 16'h0000);
        issue(OP_RELATIVE, 16'd6553);
        issue(OP_RELATIVE, 16'(-6553));
        issue(OP_SET_TARGET, 16'h0000);
        issue(OP_TICK, 16'h0000);
        issue(OP_TICK, 16'd1000);
        issue(OP_TICK, 16'hFFFF);
        issue(OP_SET_TARGET, 16'hFFFF);
        issue(OP_TICK, 16'h0000);
        issue(OP_TICK, 16'hFFFF);
        issue(OP_SET_TARGET, 16'h8000);
        issue(OP_RELATIVE, 16'h7FFF);
        issue(OP_TICK, 16'd10);
        issue(OP_RELATIVE, 16'h8000);
        issue(OP_TICK, 16'd5);
        issue(OP_TICK, 16'd3000);
        issue(OP_STOP, 16'h0000);
        issue(OP_TICK, 16'd100);
        issue(OP_RELATIVE, 16'h0000);
        issue(OP_SET_TARGET, 16'h4000);
        issue(OP_TICK, 16'h0000);
        issue(OP_TICK, 16'd860);
        issue(OP_RELATIVE, 16'd6554);
        issue(OP_RELATIVE, 16'(-6554));

        set_travel(16'd201, 11'd1800);
        run_random(320);
        set_travel(16'hFFFF, 11'd1);
        run_random(320);
        set_travel(16'hFFFF, 11'd1800);
        run_random(320);
        set_travel(16'd201, 11'd1);
        run_random(320);
        set_travel(16'($urandom_range(201, 65535)), 11'($urandom_range(1, 1800)));
        run_random(280);
        set_travel(MAX_POSITION_RESET, WIDE_ANGLE_RESET);
        calm = 1'b1;
        run_random(280);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d result beats under %0d settings,",
                 items_sent, checked, settings_used);
        $display("spanning travel 201 to 65535 ms and wide angle 1 to 1800.");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
